// ----- hdl/unicycle_pose_integrator_macros.svh -----
// Assertion helpers for the pose integrator.
`ifndef UNICYCLE_POSE_INTEGRATOR_MACROS_SVH
`define UNICYCLE_POSE_INTEGRATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define UPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define UPI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/upi_pkg.sv -----
package upi_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = 5;

  localparam logic [1:0] CMD_SET_VEL = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [31:0] RAD_TO_BANG  = 32'sd683565276;

  // Queue entry between the front end and the integrator.
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic [16:0]        dt;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic [15:0]        lh;
  } item_t;

  // Arctangent table, 32-bit binary angle.
  function automatic logic [29:0] atan_lut(input logic [StepW-1:0] i);
    logic [29:0] v;
    begin
      case (i)
        5'd0: v = 30'd536870912;  5'd1: v = 30'd316933406;
        5'd2: v = 30'd167458907;  5'd3: v = 30'd85004756;
        5'd4: v = 30'd42667331;   5'd5: v = 30'd21354465;
        5'd6: v = 30'd10679838;   5'd7: v = 30'd5340245;
        5'd8: v = 30'd2670163;    5'd9: v = 30'd1335087;
        5'd10: v = 30'd667544;    5'd11: v = 30'd333772;
        5'd12: v = 30'd166886;    5'd13: v = 30'd83443;
        5'd14: v = 30'd41722;     5'd15: v = 30'd20861;
        5'd16: v = 30'd10430;     5'd17: v = 30'd5215;
        5'd18: v = 30'd2608;      5'd19: v = 30'd1304;
        5'd20: v = 30'd652;       5'd21: v = 30'd326;
        5'd22: v = 30'd163;       5'd23: v = 30'd81;
        default: v = 30'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- hdl/upi_front.sv -----
module upi_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  upi_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_ready,
  output upi_pkg::item_t q_item
);
  import upi_pkg::*;

  // Two-entry queue; long ticks are clamped as they enter.
  item_t mem_r [2];
  logic  wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t cl;

  always_comb begin
    cl = in_item;
    if (in_item.dt[16]) cl.dt = 17'h10000;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= cl;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

// ----- hdl/upi_cordic.sv -----
module upi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import upi_pkg::*;

  // One micro-rotation per cycle.
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic flip_r, busy_r;
  logic [StepW-1:0] i_r;
  logic signed [32:0] za;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  always_comb begin
    za = {angle[31], angle};
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = 33'(atan_lut(i_r));
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; i_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; i_r <= '0;
        x_r <= CORDIC_START; y_r <= '0;
        if (za > 33'sd1073741824) begin
          z_r <= za - 33'sd2147483648; flip_r <= 1'b1;
        end else if (za < -33'sd1073741824) begin
          z_r <= za + 33'sd2147483648; flip_r <= 1'b1;
        end else begin
          z_r <= za; flip_r <= 1'b0;
        end
      end else if (busy_r) begin
        if (!z_r[32]) begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == StepW'(CordicSteps - 1)) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hdl/upi_divider.sv -----
module upi_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [79:0] num,
  input  logic signed [47:0] den,
  output logic               done,
  output logic signed [79:0] quo
);
  // Restoring division on magnitudes, one bit a cycle, truncating toward zero.
  logic [79:0] q_r;
  logic [47:0] d_r;
  logic [48:0] rem_r;
  logic neg_r, busy_r;
  logic [6:0] n_r;
  logic [48:0] sh, df;

  always_comb begin
    sh = {rem_r[47:0], q_r[79]};
    df = sh - {1'b0, d_r};
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; n_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; n_r <= '0; rem_r <= '0;
        q_r <= num[79] ? 80'(-num) : 80'(num);
        d_r <= den[47] ? 48'(-den) : 48'(den);
        neg_r <= num[79] ^ den[47];
      end else if (busy_r) begin
        if (!df[48]) begin
          rem_r <= df; q_r <= {q_r[78:0], 1'b1};
        end else begin
          rem_r <= sh; q_r <= {q_r[78:0], 1'b0};
        end
        n_r <= n_r + 1'b1;
        if (n_r == 7'd79) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hdl/upi_back.sv -----
module upi_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    thresh,
  input  logic           q_valid,
  output logic           q_ready,
  input  upi_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]    out_heading,
  output logic           out_saturated
);
  import upi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CORD0, S_TURN, S_CORD1, S_DIFF, S_PROD, S_DIVX, S_DIVY,
    S_STR, S_ADD, S_OUT
  } state_t;

  state_t st_r;
  logic signed [31:0] x_r, y_r, v_r, w_r;
  logic [15:0] h_r;
  item_t it_r;
  logic signed [31:0] s_r, dy_r;
  logic signed [33:0] c0_r, s0_r, c1_r, s1_r;
  logic [31:0] h1_r;
  logic signed [79:0] nx_r, ny_r, dx_r, ddy_r;
  logic straight_r, sat_r;

  // Shared CORDIC and divider.
  logic cs, cd, ds, dd;
  logic [31:0] ca;
  logic signed [33:0] cc, csn;
  logic signed [79:0] dn, dq;
  logic signed [47:0] dden;

  upi_cordic u_cordic (.clk, .rst_n, .start(cs), .angle(ca), .done(cd),
    .cos_o(cc), .sin_o(csn));
  upi_divider u_div (.clk, .rst_n, .start(ds), .num(dn), .den(dden),
    .done(dd), .quo(dq));

  logic signed [49:0] vdt, wdt;
  logic signed [80:0] tmul;
  logic [31:0] wabs;
  logic signed [80:0] sxs, sys;

  always_comb begin
    vdt  = 50'(v_r * $signed({1'b0, it_r.dt})) + 50'sd32768;
    wdt  = 50'(w_r * $signed({1'b0, it_r.dt})) + 50'sd32768;
    tmul = 81'(dy_r * RAD_TO_BANG) + 81'sd32768;
    wabs = w_r[31] ? 32'(-w_r) : 32'(w_r);
    sxs  = 81'(x_r) + 81'(dx_r);
    sys  = 81'(y_r) + 81'(ddy_r);
    cs = 1'b0; ca = 32'd0; ds = 1'b0; dn = nx_r;
    dden = 48'(dy_r) <<< 14;
    unique case (st_r)
      S_MUL:  begin cs = 1'b1; ca = {h_r, 16'd0}; end
      S_TURN: begin cs = 1'b1; ca = h1_r; end
      S_PROD: begin ds = 1'b1; dn = nx_r; end
      S_DIVX: begin ds = dd; dn = ny_r; end
      default: ;
    endcase
  end

  assign q_ready = (st_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0;
      x_r <= '0; y_r <= '0; h_r <= '0; v_r <= '0; w_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid && q_ready) begin
          it_r <= q_item;
          sat_r <= 1'b0;
          if (q_item.cmd == CMD_TICK) st_r <= S_MUL;
          else begin
            if (q_item.cmd == CMD_SET_VEL) begin
              v_r <= q_item.lin; w_r <= q_item.ang;
            end else if (q_item.cmd == CMD_LOAD) begin
              x_r <= q_item.lx; y_r <= q_item.ly; h_r <= q_item.lh;
            end
            st_r <= S_OUT;
          end
        end
        S_MUL: begin
          s_r <= 32'(vdt >>> 16); dy_r <= 32'(wdt >>> 16);
          st_r <= S_CORD0;
        end
        S_CORD0: if (cd) begin
          c0_r <= cc; s0_r <= csn;
          straight_r <= (wabs < {16'd0, thresh}) || (dy_r == 32'sd0);
          h1_r <= {h_r, 16'd0} + tmul[47:16];
          st_r <= ((wabs < {16'd0, thresh}) || (dy_r == 32'sd0)) ? S_STR : S_TURN;
        end
        S_STR: begin
          nx_r <= 80'(s_r * c0_r); ny_r <= 80'(s_r * s0_r);
          st_r <= S_DIFF;
        end
        S_TURN: st_r <= S_CORD1;
        S_CORD1: if (cd) begin
          c1_r <= cc; s1_r <= csn; st_r <= S_DIFF;
        end
        S_DIFF: begin
          if (straight_r) begin
            dx_r <= (nx_r + 80'sd536870912) >>> 30;
            ddy_r <= (ny_r + 80'sd536870912) >>> 30;
            st_r <= S_ADD;
          end else begin
            nx_r <= 80'(s_r * (s1_r - s0_r));
            ny_r <= 80'(s_r * (c0_r - c1_r));
            st_r <= S_PROD;
          end
        end
        S_PROD: st_r <= S_DIVX;
        S_DIVX: if (dd) begin dx_r <= dq; st_r <= S_DIVY; end
        S_DIVY: if (dd) begin
          ddy_r <= dq;
          h_r <= 16'((h1_r + 32'h8000) >> 16);
          st_r <= S_ADD;
        end
        S_ADD: begin
          x_r <= (sxs > 81'sd2147483647) ? 32'sh7fffffff :
                 (sxs < -81'sd2147483648) ? 32'sh80000000 : sxs[31:0];
          y_r <= (sys > 81'sd2147483647) ? 32'sh7fffffff :
                 (sys < -81'sd2147483648) ? 32'sh80000000 : sys[31:0];
          sat_r <= (sxs > 81'sd2147483647) || (sxs < -81'sd2147483648) ||
                   (sys > 81'sd2147483647) || (sys < -81'sd2147483648);
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_pos_x = x_r;
  assign out_pos_y = y_r;
  assign out_heading = h_r;
  assign out_saturated = sat_r;
endmodule

// ----- hdl/unicycle_pose_integrator.sv -----
// Path from an accepted input beat to out_valid: velocity, pose or idle beats
// go straight to the output state; a straight tick takes one 16-step CORDIC pass,
// an arc tick two such passes and two divisions in one shared restoring divider.
// Throughput: one item at a time in the integrator; a two-beat queue in front.
// Reset: synchronous active low; pose and velocities clear, threshold is 1.
`include "unicycle_pose_integrator_macros.svh"
module unicycle_pose_integrator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_linear_velocity,
  input  logic signed [31:0] in_angular_velocity,
  input  logic [16:0]        in_elapsed_time,
  input  logic signed [31:0] in_load_x,
  input  logic signed [31:0] in_load_y,
  input  logic [15:0]        in_load_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic               out_saturated
);
  import upi_pkg::*;

  logic [15:0] thresh_r;
  item_t in_item, q_item;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= 16'd1;
    else if (cfg_valid) thresh_r <= cfg_data;
  end

  always_comb begin
    in_item.cmd = in_command; in_item.lin = in_linear_velocity;
    in_item.ang = in_angular_velocity; in_item.dt = in_elapsed_time;
    in_item.lx = in_load_x; in_item.ly = in_load_y; in_item.lh = in_load_heading;
  end

  upi_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item);
  upi_back u_back (.clk, .rst_n, .thresh(thresh_r), .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_pos_x, .out_pos_y, .out_heading, .out_saturated);

  `UPI_ASSERT_IMP(a_take_needs_room, q_valid && q_ready, !out_valid)
  `UPI_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_pos_x))
endmodule
